FILE: rtl/four_channel_incremental_pid_motor_drive_top_assert.svh
// Assertion macros for the four-channel PID motor drive.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef FOUR_CHANNEL_INCREMENTAL_PID_MOTOR_DRIVE_TOP_ASSERT_SVH
`define FOUR_CHANNEL_INCREMENTAL_PID_MOTOR_DRIVE_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define FCPID_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define FCPID_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/fcpid_pkg.sv
// Shared types, constants and helpers of the four-channel PID motor drive.
// No dependencies; used by every module of the block.
package fcpid_pkg;

  localparam int CHANNELS_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int DUTY_W     = 24;
  localparam int ERR_W      = 18;
  localparam int OPND_W     = 19;
  localparam int PROD_W     = 36;
  localparam int ACC_W      = 38;
  localparam int STEP_W     = 25;
  localparam int CMP_W      = 17;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_DT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_DT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_DUTY  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED = 3'd7;

  // Register reset values
  localparam logic [15:0]        KP_RST       = 16'd1024;
  localparam logic [23:0]        MAX_STEP_RST = 24'd25600;
  localparam logic signed [24:0] MIN_STEP_RST = -25'sd25600;
  localparam logic [15:0]        MAX_DUTY_RST = 16'd1000;

  // Direction codes kept per channel
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  // Angle end-stops for reverse motion
  localparam logic [9:0] ESTOP_CH0_HI = 10'd239;
  localparam logic [9:0] ESTOP_CH1_LO = 10'd65;
  localparam logic [9:0] ESTOP_CH2_LO = 10'd40;
  localparam logic [9:0] ESTOP_CH3_HI = 10'd270;

  // Decay by 19/20: x = duty * 19, then floor(floor(x / 4) / 5) by reciprocal
  localparam int          DEC_X_W     = 29;
  localparam int          DEC_Y_W     = 27;
  localparam int          DEC_P_W     = 55;
  localparam int          DECAY_SHIFT = 30;
  localparam logic [4:0]  DECAY_MUL   = 5'd19;
  localparam logic [27:0] DECAY_RECIP = 28'd214748365;
  localparam logic [DUTY_W-1:0] SNAP_LEVEL = 24'd12800;

  typedef struct packed {
    logic [15:0]        kp;
    logic [15:0]        ki_dt;
    logic [15:0]        kd_dt;
    logic [23:0]        max_step;
    logic signed [24:0] min_step;
    logic [15:0]        max_duty;
    logic [15:0]        dead_duty;
    logic [14:0]        turn_speed;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       fwd_duty;
    logic [DUTY_W-1:0]       rev_duty;
    logic signed [15:0]      acc_target;
    logic signed [ERR_W-1:0] err_last;
    logic signed [ERR_W-1:0] err_prev;
    logic [1:0]              last_dir;
  } chan_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

  // True when a reverse target must be refused at this angle
  function automatic logic end_stop(input logic [1:0] ch, input logic [9:0] ang);
    logic hit;
    hit = 1'b0;
    case (ch)
      2'd0:    hit = (ang > ESTOP_CH0_HI);
      2'd1:    hit = (ang < ESTOP_CH1_LO);
      2'd2:    hit = (ang < ESTOP_CH2_LO);
      2'd3:    hit = (ang > ESTOP_CH3_HI);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

FILE: rtl/four_channel_incremental_pid_motor_drive_top.sv
// Top level of the four-channel incremental PID motor drive.
// Depends on fcpid_pkg, fcpid_cfg_regs, fcpid_state_mem, fcpid_pid_mac and the assert header.
//
// Each input transaction is one control tick for one motor channel and yields exactly one
// result transaction. The channel's state (both duties, last accepted target, the last two
// errors and the last direction) lives in a small synchronous memory that is read at the edge
// that takes the tick and, unless the tick is halted or ignored, written back when its result
// is loaded into the output register. One tick is worked on at a time. A tick that runs the
// PID goes through setpoint evaluation on the read data, four steps through the single shared
// 17x19 multiplier, step clamp, duty update and result load. A tick that decays the duty goes
// through evaluation, two steps for the 19/20 decay around its reciprocal multiply and result
// load; halted, ignored or undriven ticks go from evaluation straight to result load. The next
// tick is accepted only once the previous result is loaded and the sequencer is idle again.
// A result waits until the output register is free. No clearing pass is needed after reset.
`include "four_channel_incremental_pid_motor_drive_top_assert.svh"

module four_channel_incremental_pid_motor_drive_top #(
  parameter int CHANNELS = fcpid_pkg::CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       channel_i,
  input  logic signed [15:0]               measured_speed_i,
  input  logic signed [15:0]               target_speed_i,
  input  logic [9:0]                       joint_angle_i,
  input  logic                             halt_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       out_channel_o,
  output logic [16:0]                      compare_value_o,
  output logic                             dir_forward_o,
  output logic                             dir_reverse_o,
  output logic                             outputs_written_o,
  output logic                             target_cleared_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fcpid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fcpid_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ErrW   = fcpid_pkg::ERR_W;
  localparam int OpndW  = fcpid_pkg::OPND_W;
  localparam int AccW   = fcpid_pkg::ACC_W;
  localparam int StepW  = fcpid_pkg::STEP_W;
  localparam int DutyW  = fcpid_pkg::DUTY_W;
  localparam int CmpW   = fcpid_pkg::CMP_W;
  localparam int DecXW  = fcpid_pkg::DEC_X_W;
  localparam int DecYW  = fcpid_pkg::DEC_Y_W;
  localparam int DecPW  = fcpid_pkg::DEC_P_W;
  localparam int SumW   = DutyW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_CLAMP,
    S_ADD,
    S_DEC0,
    S_DEC1,
    S_OUT
  } state_e;

  state_e                 state_q;
  fcpid_pkg::cfg_t        cfg;
  fcpid_pkg::chan_state_t rd_st;
  fcpid_pkg::chan_state_t nst;
  fcpid_pkg::chan_state_t st_q;
  fcpid_pkg::mac_stat_t   mac_stat;

  // Latched tick
  logic [1:0]         ch_q;
  logic signed [15:0] ms_q;
  logic signed [15:0] ts_q;
  logic [9:0]         ang_q;
  logic               halt_q;

  // Work registers
  logic                    fwd_q;
  logic                    wb_q;
  logic signed [OpndW-1:0] e0_q;
  logic signed [OpndW-1:0] d1_q;
  logic signed [OpndW-1:0] d2_q;
  logic signed [StepW-1:0] inc_q;
  logic [DecYW-1:0]        y_q;

  // Pending result
  logic [CmpW-1:0] res_cmp_q;
  logic            res_fwd_q;
  logic            res_rev_q;
  logic            res_wr_q;
  logic            res_clr_q;

  // Output register
  logic            out_valid_q;
  logic [1:0]      out_ch_q;
  logic [CmpW-1:0] out_cmp_q;
  logic            out_fwd_q;
  logic            out_rev_q;
  logic            out_wr_q;
  logic            out_clr_q;

  logic in_fire;
  logic out_free;
  logic in_ch_ok;
  logic ch_ok;
  logic mac_start;
  logic signed [AccW-1:0] acc;

  // Setpoint evaluation
  logic signed [16:0]     ms_x;
  logic signed [16:0]     ts_x;
  logic [16:0]            mag;
  logic [16:0]            sp_mag;
  logic                   ts_neg;
  logic                   ts_zero;
  logic                   ts_pos;
  logic                   stop;
  logic                   prv_neg;
  logic                   prv_pos;
  logic                   opposite;
  logic                   take;
  logic                   sp_nz;
  logic                   dir_fwd_old;
  logic                   dir_rev_old;
  logic signed [ErrW-1:0] e0;

  // Step clamp and duty update
  logic signed [AccW-1:0]  max_step_x;
  logic signed [AccW-1:0]  min_step_x;
  logic signed [AccW-1:0]  inc_hi;
  logic signed [AccW-1:0]  inc_lim;
  logic [DutyW-1:0]        duty_cur;
  logic signed [SumW-1:0]  duty_sum;
  logic signed [SumW-1:0]  duty_lim;
  logic signed [SumW-1:0]  duty_sel;
  logic [DutyW-1:0]        duty_new;

  // Decay
  logic [DecXW-1:0] dec_x;
  logic [DecPW-1:0] dec_p;
  logic [DutyW-1:0] dec_raw;
  logic [DutyW-1:0] dec_new;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ch_ok   = (32'(channel_i) < 32'(CHANNELS));
  assign ch_ok      = (32'(ch_q) < 32'(CHANNELS));

  fcpid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fcpid_state_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire && in_ch_ok),
    .rd_addr_i (AW'(channel_i)),
    .rd_data_o (rd_st),
    .wr_en_i   ((state_q == S_OUT) && out_free && wb_q),
    .wr_addr_i (AW'(ch_q)),
    .wr_data_i (st_q)
  );

  assign mac_start = (state_q == S_EVAL) && ch_ok && !halt_q && sp_nz;

  fcpid_pid_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .kp_i    (cfg.kp),
    .ki_i    (cfg.ki_dt),
    .kd_i    (cfg.kd_dt),
    .e0_i    (e0_q),
    .d1_i    (d1_q),
    .d2_i    (d2_q),
    .acc_o   (acc),
    .stat_o  (mac_stat)
  );

  // Choose the setpoint: end-stop, reversal lockout, or accept
  assign ms_x    = {ms_q[15], ms_q};
  assign ts_x    = {ts_q[15], ts_q};
  assign mag     = ms_q[15] ? $unsigned(-ms_x) : $unsigned(ms_x);
  assign sp_mag  = ts_q[15] ? $unsigned(-ts_x) : $unsigned(ts_x);
  assign ts_neg  = ts_q[15];
  assign ts_zero = (ts_q == '0);
  assign ts_pos  = !ts_neg && !ts_zero;
  assign stop    = ts_neg && fcpid_pkg::end_stop(ch_q, ang_q);
  assign prv_neg = rd_st.acc_target[15];
  assign prv_pos = !prv_neg && (rd_st.acc_target != '0);
  assign opposite = (prv_neg && ts_pos) || (prv_pos && ts_neg);
  assign take    = !stop && ((mag < 17'(cfg.turn_speed)) || !opposite);
  assign sp_nz   = take && !ts_zero;
  assign dir_fwd_old = (rd_st.last_dir == fcpid_pkg::DIR_FWD);
  assign dir_rev_old = (rd_st.last_dir == fcpid_pkg::DIR_REV);
  assign e0      = $signed({1'b0, sp_mag}) - $signed({1'b0, mag});

  // Build the state to write back for this tick
  always_comb begin
    nst = rd_st;
    if (take) begin
      nst.acc_target = ts_q;
    end
    if (sp_nz) begin
      nst.err_prev = rd_st.err_last;
      nst.err_last = e0;
      nst.last_dir = ts_pos ? fcpid_pkg::DIR_FWD : fcpid_pkg::DIR_REV;
      if (ts_pos) begin
        nst.rev_duty = '0;
      end else begin
        nst.fwd_duty = '0;
      end
    end else if (dir_fwd_old) begin
      nst.rev_duty = '0;
    end else if (dir_rev_old) begin
      nst.fwd_duty = '0;
    end
  end

  // Clamp the PID step, then add it to the active duty and clamp that
  assign max_step_x = $signed({{(AccW-24){1'b0}}, cfg.max_step});
  assign min_step_x = AccW'(cfg.min_step);
  assign inc_hi     = (acc > max_step_x) ? max_step_x : acc;
  assign inc_lim    = (inc_hi < min_step_x) ? min_step_x : inc_hi;

  assign duty_cur = fwd_q ? st_q.fwd_duty : st_q.rev_duty;
  assign duty_sum = $signed({2'b00, duty_cur}) + $signed({inc_q[StepW-1], inc_q});
  assign duty_lim = $signed({2'b00, cfg.max_duty, 8'h00});

  always_comb begin
    duty_sel = (duty_sum >= duty_lim) ? duty_lim : duty_sum;
    if (duty_sel <= 0) begin
      duty_sel = '0;
    end
  end

  assign duty_new = duty_sel[DutyW-1:0];

  // Decay by 19/20 through a reciprocal multiply, snap small duty to zero
  assign dec_x   = DecXW'(duty_cur) * DecXW'(fcpid_pkg::DECAY_MUL);
  assign dec_p   = DecPW'(y_q) * DecPW'(fcpid_pkg::DECAY_RECIP);
  assign dec_raw = DutyW'(dec_p >> fcpid_pkg::DECAY_SHIFT);
  assign dec_new = (dec_raw < fcpid_pkg::SNAP_LEVEL) ? '0 : dec_raw;

  // Sequencer with work registers and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      ms_q        <= '0;
      ts_q        <= '0;
      ang_q       <= '0;
      halt_q      <= 1'b0;
      st_q        <= '0;
      fwd_q       <= 1'b0;
      wb_q        <= 1'b0;
      e0_q        <= '0;
      d1_q        <= '0;
      d2_q        <= '0;
      inc_q       <= '0;
      y_q         <= '0;
      res_cmp_q   <= '0;
      res_fwd_q   <= 1'b0;
      res_rev_q   <= 1'b0;
      res_wr_q    <= 1'b0;
      res_clr_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_ch_q    <= '0;
      out_cmp_q   <= '0;
      out_fwd_q   <= 1'b0;
      out_rev_q   <= 1'b0;
      out_wr_q    <= 1'b0;
      out_clr_q   <= 1'b0;
    end else begin
      // Drop the result once the consumer takes it, unless a new one loads
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            ch_q    <= channel_i;
            ms_q    <= measured_speed_i;
            ts_q    <= target_speed_i;
            ang_q   <= joint_angle_i;
            halt_q  <= halt_i;
            state_q <= S_EVAL;
          end
        end

        S_EVAL: begin
          st_q      <= nst;
          fwd_q     <= sp_nz ? ts_pos : dir_fwd_old;
          e0_q      <= {e0[ErrW-1], e0};
          d1_q      <= {e0[ErrW-1], e0} - {rd_st.err_last[ErrW-1], rd_st.err_last};
          d2_q      <= {e0[ErrW-1], e0}
                       - {rd_st.err_last, 1'b0}
                       + {rd_st.err_prev[ErrW-1], rd_st.err_prev};
          res_cmp_q <= '0;
          res_fwd_q <= 1'b0;
          res_rev_q <= 1'b0;
          // Ignored ticks report nothing; halt reports a forced zero; keep state on both
          res_wr_q  <= ch_ok && halt_q;
          res_clr_q <= ch_ok && (halt_q || stop);
          wb_q      <= ch_ok && !halt_q;
          if (!ch_ok || halt_q) begin
            state_q <= S_OUT;
          end else if (sp_nz) begin
            state_q <= S_MUL;
          end else if (dir_fwd_old || dir_rev_old) begin
            state_q <= S_DEC0;
          end else begin
            state_q <= S_OUT;
          end
        end

        S_MUL: begin
          if (mac_stat.done) begin
            state_q <= S_CLAMP;
          end
        end

        S_CLAMP: begin
          inc_q   <= inc_lim[StepW-1:0];
          state_q <= S_ADD;
        end

        S_ADD: begin
          if (fwd_q) begin
            st_q.fwd_duty <= duty_new;
          end else begin
            st_q.rev_duty <= duty_new;
          end
          res_cmp_q <= CmpW'(duty_new[DutyW-1:8]) + CmpW'(cfg.dead_duty);
          res_fwd_q <= fwd_q;
          res_rev_q <= !fwd_q;
          res_wr_q  <= 1'b1;
          state_q   <= S_OUT;
        end

        S_DEC0: begin
          y_q     <= dec_x[DecXW-1:2];
          state_q <= S_DEC1;
        end

        S_DEC1: begin
          if (fwd_q) begin
            st_q.fwd_duty <= dec_new;
          end else begin
            st_q.rev_duty <= dec_new;
          end
          res_cmp_q <= CmpW'(dec_new[DutyW-1:8]);
          res_fwd_q <= fwd_q;
          res_rev_q <= !fwd_q;
          res_wr_q  <= 1'b1;
          state_q   <= S_OUT;
        end

        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ch_q    <= ch_q;
            out_cmp_q   <= res_cmp_q;
            out_fwd_q   <= res_fwd_q;
            out_rev_q   <= res_rev_q;
            out_wr_q    <= res_wr_q;
            out_clr_q   <= res_clr_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_channel_o     = out_ch_q;
  assign compare_value_o   = out_cmp_q;
  assign dir_forward_o     = out_fwd_q;
  assign dir_reverse_o     = out_rev_q;
  assign outputs_written_o = out_wr_q;
  assign target_cleared_o  = out_clr_q;

  // Only one tick is in flight at a time
  `FCPID_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "tick accepted while busy")
  // An undriven result carries a zero compare and no pins
  `FCPID_ASSERT_SAME(a_undriven_zero, out_valid_o && !outputs_written_o, compare_value_o == '0 && !dir_forward_o && !dir_reverse_o, "undriven result not zero")
  // Never drive both direction pins
  `FCPID_ASSERT_SAME(a_pins_exclusive, out_valid_o, !(dir_forward_o && dir_reverse_o), "both direction pins high")
  // The multiplier finishes only while the sequencer waits on it
  `FCPID_ASSERT_SAME(a_mac_done_in_mul, mac_stat.done, state_q == S_MUL, "PID sum done outside multiply phase")

endmodule

FILE: rtl/fcpid_cfg_regs.sv
// Configuration register bank of the PID motor drive.
// Depends on fcpid_pkg for the register indexes, reset values and cfg_t.
module fcpid_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fcpid_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fcpid_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output fcpid_pkg::cfg_t                     cfg_o
);

  fcpid_pkg::cfg_t cfg_q;
  logic            wr_en;

  // Always ready: every write is taken when it is offered
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Hold register values, update the addressed one on a transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp         <= fcpid_pkg::KP_RST;
      cfg_q.ki_dt      <= '0;
      cfg_q.kd_dt      <= '0;
      cfg_q.max_step   <= fcpid_pkg::MAX_STEP_RST;
      cfg_q.min_step   <= fcpid_pkg::MIN_STEP_RST;
      cfg_q.max_duty   <= fcpid_pkg::MAX_DUTY_RST;
      cfg_q.dead_duty  <= '0;
      cfg_q.turn_speed <= '0;
    end else if (wr_en) begin
      case (cfg_index_i)
        fcpid_pkg::REG_KP:         cfg_q.kp         <= cfg_data_i[15:0];
        fcpid_pkg::REG_KI_DT:      cfg_q.ki_dt      <= cfg_data_i[15:0];
        fcpid_pkg::REG_KD_DT:      cfg_q.kd_dt      <= cfg_data_i[15:0];
        fcpid_pkg::REG_MAX_STEP:   cfg_q.max_step   <= cfg_data_i[23:0];
        fcpid_pkg::REG_MIN_STEP:   cfg_q.min_step   <= $signed(cfg_data_i[24:0]);
        fcpid_pkg::REG_MAX_DUTY:   cfg_q.max_duty   <= cfg_data_i[15:0];
        fcpid_pkg::REG_DEAD_DUTY:  cfg_q.dead_duty  <= cfg_data_i[15:0];
        fcpid_pkg::REG_TURN_SPEED: cfg_q.turn_speed <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/fcpid_state_mem.sv
// Per-channel state memory: one synchronous read port, one write port.
// Depends on fcpid_pkg for chan_state_t; entries never written read as zero.
module fcpid_state_mem #(
  parameter int CHANNELS = fcpid_pkg::CHANNELS_DEF,
  parameter int AW       = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  output fcpid_pkg::chan_state_t rd_data_o,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  fcpid_pkg::chan_state_t wr_data_i
);

  fcpid_pkg::chan_state_t mem_q [CHANNELS];
  fcpid_pkg::chan_state_t rd_q;
  logic [CHANNELS-1:0]    valid_q;
  logic                   rd_vld_q;

  // Storage array and registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Track written entries so that reset state reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/fcpid_pid_mac.sv
// Shared multiply-accumulate unit forming the incremental PID sum.
// Depends on fcpid_pkg; one 17x19 product per cycle over four steps.
module fcpid_pid_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [15:0]                          kp_i,
  input  logic [15:0]                          ki_i,
  input  logic [15:0]                          kd_i,
  input  logic signed [fcpid_pkg::OPND_W-1:0]  e0_i,
  input  logic signed [fcpid_pkg::OPND_W-1:0]  d1_i,
  input  logic signed [fcpid_pkg::OPND_W-1:0]  d2_i,
  output logic signed [fcpid_pkg::ACC_W-1:0]   acc_o,
  output fcpid_pkg::mac_stat_t                 stat_o
);

  localparam logic [1:0] LAST_STEP = 2'd3;
  localparam int         AccW      = fcpid_pkg::ACC_W;

  logic [1:0]                            cnt_q;
  logic                                  busy_q;
  logic [15:0]                           gain_sel;
  logic signed [fcpid_pkg::OPND_W-1:0]   opnd_sel;
  logic signed [fcpid_pkg::PROD_W-1:0]   mul_p;
  logic signed [fcpid_pkg::PROD_W-1:0]   prod_q;
  logic signed [fcpid_pkg::ACC_W-1:0]    acc_q;

  // Pick the gain and error term of the current step
  always_comb begin
    case (cnt_q)
      2'd0: begin
        gain_sel = kp_i;
        opnd_sel = d1_i;
      end
      2'd1: begin
        gain_sel = ki_i;
        opnd_sel = e0_i;
      end
      default: begin
        gain_sel = kd_i;
        opnd_sel = d2_i;
      end
    endcase
  end

  assign mul_p = $signed({1'b0, gain_sel}) * opnd_sel;

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Register each product, add it in the following step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else if (busy_q) begin
      prod_q <= mul_p;
      if (cnt_q != 2'd0) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end
  end

  assign acc_o       = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == LAST_STEP);

endmodule
